FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the asynchronous reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Expression that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

FILE: hw/rtl/mbe_pkg.sv
package mbe_pkg;

	// Field widths of the words
	localparam int C_W    = 32;
	localparam int ITER_W = 16;
	localparam int CNT_W  = 32;

	// Iteration limit after reset
	localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd1000;

	// Input word: one complex point
	typedef struct packed {
		logic signed [C_W-1:0] c_real;
		logic signed [C_W-1:0] c_imag;
	} mbe_in_t;

	// Output word: one result per point
	typedef struct packed {
		logic              escaped;
		logic [ITER_W-1:0] iterations_used;
		logic [CNT_W-1:0]  outside_count;
	} mbe_out_t;

	// Status from the iteration engine to the top level
	typedef struct packed {
		logic              busy;
		logic              done;
		logic              escaped;
		logic [ITER_W-1:0] used;
	} mbe_stat_t;

	// Iteration sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_SQI,
		ST_CROSS,
		ST_UPDATE,
		ST_DONE
	} mbe_state_t;

endpackage

FILE: hw/rtl/mbe_mul.sv
// Shared unsigned magnitude multiplier with registered product.
module mbe_mul #(
	parameter int MW = 34
) (
	input  logic            clk,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic [2*MW-1:0] prod
);
	logic [2*MW-1:0] prod_q;

	// One product per cycle, available the next cycle
	always_ff @(posedge clk) begin
		prod_q <= {{MW{1'b0}}, a} * {{MW{1'b0}}, b};
	end

	assign prod = prod_q;

endmodule

FILE: hw/rtl/mbe_iter.sv
`include "assert_macros.svh"

// Escape-time iteration engine: sequencer plus z datapath around one multiplier.
module mbe_iter #(
	parameter int FRAC_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  mbe_pkg::mbe_in_t              point,
	input  logic [mbe_pkg::ITER_W-1:0]    limit,
	input  logic                          take,
	output mbe_pkg::mbe_stat_t            stat
);
	import mbe_pkg::*;

	// z holds up to |36| after the first update, so 6 integer bits plus sign
	localparam int ZW     = FRAC_BITS + 7;
	localparam int MW     = ZW - 1;
	localparam int PW     = 2 * MW;
	localparam int XW     = (ZW > C_W) ? ZW : C_W;
	localparam int LIM_SH = FRAC_BITS + 2;
	localparam logic [C_W:0] LIM_C = (LIM_SH < C_W + 1) ? ((C_W + 1)'(1) << LIM_SH) : '0;
	localparam logic [PW:0]  ESC_T = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

	mbe_state_t state_q, state_d;

	logic signed [ZW-1:0]     zr_q, zi_q, cr_q, ci_q;
	logic [PW-1:0]            sqr_q, sqi_q;
	logic [ITER_W-1:0]        used_q, lim_q;
	logic                     esc_q, first_q;

	logic signed [C_W:0]      crx_w, cix_w;
	logic [C_W:0]             crm_w, cim_w;
	logic                     large_w;
	logic signed [XW-1:0]     crl_w, cil_w;
	logic [MW-1:0]            mr_w, mi_w, op_a, op_b;
	logic [PW-1:0]            prod;
	logic [PW:0]              mag2_w;
	logic                     hit_w, stop_w;
	logic signed [ZW:0]       nr_w, ni_w, cross_w;
	logic [MW-1:0]            cm_w;
	logic                     neg_w;

	// Large point check on the incoming word
	always_comb begin
		crx_w   = (C_W + 1)'(point.c_real);
		cix_w   = (C_W + 1)'(point.c_imag);
		crm_w   = crx_w[C_W] ? unsigned'(-crx_w) : unsigned'(crx_w);
		cim_w   = cix_w[C_W] ? unsigned'(-cix_w) : unsigned'(cix_w);
		large_w = (LIM_SH < C_W + 1) && ((crm_w >= LIM_C) || (cim_w >= LIM_C));
		crl_w   = XW'(point.c_real);
		cil_w   = XW'(point.c_imag);
	end

	// Magnitudes and multiplier operand select
	always_comb begin
		mr_w = zr_q[ZW-1] ? MW'(-zr_q) : MW'(zr_q);
		mi_w = zi_q[ZW-1] ? MW'(-zi_q) : MW'(zi_q);
		op_a = (state_q == ST_SQI) ? mi_w : mr_w;
		op_b = (state_q == ST_SQR) ? mr_w : mi_w;
	end

	mbe_mul #(.MW(MW)) u_mul (
		.clk  (clk),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	// Escape test: exact zr^2 + zi^2 against 4 (prod holds zi^2 in ST_CROSS)
	always_comb begin
		mag2_w = {1'b0, sqr_q} + {1'b0, prod};
		hit_w  = mag2_w > ESC_T;
		stop_w = !first_q && (hit_w || (used_q == lim_q));
	end

	// Update: squares truncated, cross term truncated toward zero (prod holds zr*zi)
	always_comb begin
		nr_w    = signed'({2'b00, sqr_q[FRAC_BITS +: MW]})
		        - signed'({2'b00, sqi_q[FRAC_BITS +: MW]})
		        + (ZW + 1)'(cr_q);
		cm_w    = prod[FRAC_BITS +: MW];
		neg_w   = zr_q[ZW-1] ^ zi_q[ZW-1];
		cross_w = neg_w ? -signed'({2'b00, cm_w}) : signed'({2'b00, cm_w});
		ni_w    = signed'({cross_w[ZW-1:0], 1'b0}) + (ZW + 1)'(ci_q);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ((limit == '0) || large_w) ? ST_DONE : ST_SQR;
				end
			end
			ST_SQR:    state_d = ST_SQI;
			ST_SQI:    state_d = ST_CROSS;
			ST_CROSS:  state_d = stop_w ? ST_DONE : ST_UPDATE;
			ST_UPDATE: state_d = ST_SQR;
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cr_q    <= crl_w[ZW-1:0];
					ci_q    <= cil_w[ZW-1:0];
					zr_q    <= crl_w[ZW-1:0];
					zi_q    <= cil_w[ZW-1:0];
					lim_q   <= limit;
					first_q <= 1'b1;
					esc_q   <= (limit != '0) && large_w;
					used_q  <= ((limit != '0) && large_w) ? ITER_W'(1) : '0;
				end
			end
			ST_SQI: begin
				sqr_q <= prod;
			end
			ST_CROSS: begin
				sqi_q <= prod;
				esc_q <= !first_q && hit_w;
			end
			ST_UPDATE: begin
				zr_q    <= nr_w[ZW-1:0];
				zi_q    <= ni_w[ZW-1:0];
				used_q  <= used_q + ITER_W'(1);
				first_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign stat.busy    = (state_q != ST_IDLE);
	assign stat.done    = (state_q == ST_DONE);
	assign stat.escaped = esc_q;
	assign stat.used    = used_q;

	`ASSERT_CLK(a_used_in_limit, clk, arst_n, (state_q != ST_IDLE) |-> (used_q <= lim_q), "iteration count past limit")
	`ASSERT_CLK(a_inside_at_limit, clk, arst_n, (state_q == ST_DONE && !esc_q) |-> (used_q == lim_q), "inside point finished early")
	`ASSERT_NEVER(a_escape_nonzero, clk, arst_n, (state_q == ST_DONE) && esc_q && (used_q == '0), "escape with no iteration")

endmodule

FILE: hw/rtl/mandelbrot_escape_test.sv
// Mandelbrot escape-time test. Each input word is a point c in signed fixed point
// (FRAC_BITS fraction bits); z starts at c and z = z*z + c is iterated up to
// max_iterations times, stopping at the first update with |z|^2 > 4. Every
// iteration runs its steps in order on the one shared multiplier (zr^2, zi^2,
// zr*zi, then the update). A point with a part of magnitude 4 or more, or a
// zero limit, goes straight to the result without iterating. One point is
// worked at a time: in_stall stays high until the result has moved into the
// output register, which frees the input while the result waits there.
// outside_count is the saturating number of escaped points since reset.
// max_iterations resets to 1000; the user must write it only while the block
// is idle, as the block itself does not enforce this.
`include "assert_macros.svh"

module mandelbrot_escape_test #(
	parameter int FRAC_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mbe_pkg::mbe_in_t              in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mbe_pkg::mbe_out_t             out_word,
	input  logic                          cfg_we,
	input  logic [mbe_pkg::ITER_W-1:0]    cfg_wdata
);
	import mbe_pkg::*;

	logic [ITER_W-1:0] max_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              out_valid_q;
	mbe_out_t          out_q;
	mbe_stat_t         stat;
	logic              start, take;

	assign in_stall = stat.busy;
	assign start    = in_valid && !in_stall;
	assign take     = stat.done && (!out_valid_q || !out_stall);

	mbe_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.point  (in_word),
		.limit  (max_q),
		.take   (take),
		.stat   (stat)
	);

	// Saturating outside count
	assign cnt_d = (stat.escaped && (cnt_q != '1)) ? cnt_q + CNT_W'(1) : cnt_q;

	// Config register, outside count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= MAX_ITER_RST;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (take) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.escaped         <= stat.escaped;
			out_q.iterations_used <= stat.used;
			out_q.outside_count   <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`ASSERT_CLK(a_cnt_monotonic, clk, arst_n, 1'b1 |=> (cnt_q >= $past(cnt_q)), "outside count went down")
	`ASSERT_CLK(a_result_held, clk, arst_n, (stat.done && out_valid_q && out_stall) |=> stat.done, "result dropped while output full")
	`ASSERT_CLK(a_take_loads, clk, arst_n, take |=> out_valid_q, "result taken but output not valid")

endmodule
